>>> design/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg - shared definitions for the heightmap box smoother
// Sizes, register map, result request type and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  // Geometry limits
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_ROWS);

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 20;   // nine 16-bit samples
  localparam int RES_W     = 20;   // 16.4 fixed point
  localparam int CNT_W     = 4;    // neighbour count, 1..9
  localparam int WIN_N     = 9;    // 3x3 window

  // Configuration port
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;
  localparam int WREG_W    = 11;
  localparam int RREG_W    = 13;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_IMAGE_ROWS  = 1'b1
  } reg_idx_t;

  // Neighbour counts with a divide path of their own
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_SIX   = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_NINE  = CNT_W'(9);

  // Reciprocals, exact for any SUM_W-bit dividend
  localparam int          RECIP_W   = 21;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(1398102);  // ceil(2^22/3)
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(1864136);  // ceil(2^24/9)
  localparam int          SHIFT3    = 22;
  localparam int          SHIFT9    = 24;
  // Wide enough for a full SUM_W-bit quotient field above either shift
  localparam int          PROD_W    = SHIFT9 + SUM_W;

  // One result on its way through the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             frame_done;
  } div_req_t;

  // Register value to last index, with out-of-range values clamped
  function automatic logic [COL_W-1:0] width_last(input logic [WREG_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_WIDTH) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(v - WREG_W'(1));
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] rows_last(input logic [RREG_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_ROWS) begin
      r = ROW_W'(MAX_ROWS - 1);
    end else begin
      r = ROW_W'(v - RREG_W'(1));
    end
    return r;
  endfunction

  // Fraction tables: floor(16*r/3), floor(8*r/3), floor(16*r/9)
  function automatic logic [3:0] frac16_3(input logic [1:0] r);
    logic [3:0] f;
    case (r)
      2'd0:    f = 4'd0;
      2'd1:    f = 4'd5;
      2'd2:    f = 4'd10;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] frac8_3(input logic [1:0] r);
    logic [3:0] f;
    case (r)
      2'd0:    f = 4'd0;
      2'd1:    f = 4'd2;
      2'd2:    f = 4'd5;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] frac16_9(input logic [3:0] r);
    logic [3:0] f;
    case (r)
      4'd0:    f = 4'd0;
      4'd1:    f = 4'd1;
      4'd2:    f = 4'd3;
      4'd3:    f = 4'd5;
      4'd4:    f = 4'd7;
      4'd5:    f = 4'd8;
      4'd6:    f = 4'd10;
      4'd7:    f = 4'd12;
      4'd8:    f = 4'd14;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

>>> design/hbs_sample_if.sv
// ----------------------------------------------------------------------------
// hbs_sample_if - heightmap sample channel
// Valid/ready channel carrying one height sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbs_sample_if;
  logic                         valid;
  logic                         ready;
  logic [hbs_pkg::SAMPLE_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

`default_nettype wire

>>> design/hbs_result_if.sv
// ----------------------------------------------------------------------------
// hbs_result_if - smoothed result channel
// Valid/ready channel carrying one smoothed position per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbs_result_if;
  logic                      valid;
  logic                      ready;
  logic [hbs_pkg::RES_W-1:0] smoothed_height;
  logic [hbs_pkg::ROW_W-1:0] out_row;
  logic [hbs_pkg::COL_W-1:0] out_col;
  logic                      last_of_run;
  logic                      frame_done;

  modport source (output valid, output smoothed_height, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input smoothed_height, input out_row, input out_col,
                  input last_of_run, input frame_done, output ready);
endinterface

`default_nettype wire

>>> design/hbs_mean_div.sv
// ----------------------------------------------------------------------------
// hbs_mean_div - neighbourhood sum to 16.4 mean
// Two-stage constant divide by the neighbour count, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_mean_div (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   req_valid,
  output logic                  req_ready,
  input  wire hbs_pkg::div_req_t req,
  hbs_result_if.source          results
);

  logic                          a_valid;
  hbs_pkg::div_req_t             a_req;
  logic                          b_valid;
  hbs_pkg::div_req_t             b_req;
  logic [hbs_pkg::SUM_W-1:0]     b_q;

  logic                          out_free;
  logic                          b_free;
  logic                          a_free;
  logic                          a_nine;
  logic [hbs_pkg::PROD_W-1:0]    prod;
  logic [hbs_pkg::SUM_W-1:0]     q_calc;
  logic [hbs_pkg::SUM_W-1:0]     q3x;
  logic [hbs_pkg::SUM_W-1:0]     q9x;
  logic [1:0]                    rem3;
  logic [3:0]                    rem9;
  logic [hbs_pkg::RES_W-1:0]     mean;

  // Stall chain from the output backwards
  assign out_free  = !results.valid || results.ready;
  assign b_free    = !b_valid || out_free;
  assign a_free    = !a_valid || b_free;
  assign req_ready = a_free;

  // Quotient by reciprocal: divide by 9, or by 3 (count 6 is 2 x 3)
  assign a_nine = (a_req.cnt == hbs_pkg::CNT_NINE);
  assign prod   = hbs_pkg::PROD_W'(a_req.sum) *
                  hbs_pkg::PROD_W'(a_nine ? hbs_pkg::RECIP9 : hbs_pkg::RECIP3);
  assign q_calc = a_nine ? prod[hbs_pkg::SHIFT9 +: hbs_pkg::SUM_W]
                         : prod[hbs_pkg::SHIFT3 +: hbs_pkg::SUM_W];

  // Remainder and final fixed-point mean
  always_comb begin
    q3x  = b_q + (b_q << 1);
    q9x  = b_q + (b_q << 3);
    rem3 = 2'(b_req.sum - q3x);
    rem9 = 4'(b_req.sum - q9x);
    case (b_req.cnt)
      hbs_pkg::CNT_ONE:   mean = b_req.sum << 4;
      hbs_pkg::CNT_TWO:   mean = b_req.sum << 3;
      hbs_pkg::CNT_FOUR:  mean = b_req.sum << 2;
      hbs_pkg::CNT_THREE: mean = (b_q << 4) + hbs_pkg::RES_W'(hbs_pkg::frac16_3(rem3));
      hbs_pkg::CNT_SIX:   mean = (b_q << 3) + hbs_pkg::RES_W'(hbs_pkg::frac8_3(rem3));
      hbs_pkg::CNT_NINE:  mean = (b_q << 4) + hbs_pkg::RES_W'(hbs_pkg::frac16_9(rem9));
      default:            mean = '0;
    endcase
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= req_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (out_free) begin
        results.valid <= b_valid;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (a_free) begin
      a_req <= req;
    end
    if (b_free) begin
      b_req <= a_req;
      b_q   <= q_calc;
    end
    if (out_free) begin
      results.smoothed_height <= mean;
      results.out_row         <= b_req.row;
      results.out_col         <= b_req.col;
      results.last_of_run     <= b_req.last;
      results.frame_done      <= b_req.frame_done;
    end
  end

endmodule

`default_nettype wire

>>> design/heightmap_box_smoother_top.sv
// ----------------------------------------------------------------------------
// heightmap_box_smoother_top - edge-normalised 3x3 mean filter
// Line-buffered raster-order heightmap smoother with an APB register port.
// ----------------------------------------------------------------------------
// Samples enter in raster order and each position leaves as the floored mean
// of itself and its in-bounds neighbours, in 16.4 fixed point, tagged with its
// row and column, as soon as its last neighbour has arrived. A sample is taken
// every clock as long as each one completes at most one position and the
// output does not stall. The sample that ends a row completes up to two
// positions, as does every sample after the first on the last row, and the
// last sample of the map completes up to four; such a sample holds the input
// while its results leave, one per clock unless the output stalls. The two
// line buffers are single memories read when a sample is taken; a narrow map
// that revisits the same column back to back is served by forwarding, with
// no stall. Results pass the RMW stage, the result job, the divider stages
// and the output register. Writing image_width or image_rows restarts the
// frame at row 0, column 0; write them only when the block is idle.
// Out-of-range sizes are clamped to 1..1024 columns and 1..4096 rows.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_box_smoother_top (
  input  wire                          clk,
  input  wire                          rst,
  hbs_sample_if.sink                   samples,
  hbs_result_if.source                 results,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [hbs_pkg::PADDR_W-1:0]   paddr,
  input  wire [hbs_pkg::PDATA_W-1:0]   pwdata,
  output logic [hbs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int SW = hbs_pkg::SAMPLE_W;
  localparam int CW = hbs_pkg::COL_W;
  localparam int RW = hbs_pkg::ROW_W;

  // Configuration, held as last column / last row
  logic [CW-1:0]      wm1;
  logic [RW-1:0]      rm1;
  logic               cfg_wr;
  hbs_pkg::reg_idx_t  cfg_sel;

  // Position of the next sample
  logic [CW-1:0]      col_cnt;
  logic [RW-1:0]      row_cnt;

  // Line buffers
  logic [SW-1:0]      older_mem [hbs_pkg::MAX_WIDTH];
  logic [SW-1:0]      newer_mem [hbs_pkg::MAX_WIDTH];
  logic [SW-1:0]      older_q;
  logic [SW-1:0]      newer_q;
  logic               fwd;
  logic [SW-1:0]      wr_older;
  logic [SW-1:0]      wr_newer;

  // Read-modify-write stage
  logic               s1_valid;
  logic [RW-1:0]      s1_r;
  logic [CW-1:0]      s1_c;
  logic [SW-1:0]      s1_sample;
  logic [SW-1:0]      older_eff;
  logic [SW-1:0]      newer_eff;
  logic [3:0]         s1_mask;
  logic               s1_done;
  logic               s1_free;
  logic               s1_load;
  logic               accept;

  // Window
  logic [SW-1:0]      win      [hbs_pkg::WIN_N];
  logic [SW-1:0]      win_next [hbs_pkg::WIN_N];

  // Result job: window snapshot plus the positions still to emit
  logic               job_valid;
  logic [SW-1:0]      job_win [hbs_pkg::WIN_N];
  logic [RW-1:0]      job_r;
  logic [CW-1:0]      job_c;
  logic [3:0]         job_mask;
  logic               job_rge1;
  logic               job_rge2;
  logic               job_cge1;
  logic               job_cge2;
  logic [1:0]         idx;
  logic [3:0]         job_rest;
  logic               job_last;
  logic               job_emit;
  logic               job_free;
  logic [2:0]         rmask;
  logic [2:0]         cmask;
  logic [1:0]         nrows;
  logic [1:0]         ncols;
  hbs_pkg::div_req_t  req;
  logic               req_ready;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = hbs_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_sel)
      hbs_pkg::REG_IMAGE_WIDTH:
        prdata = hbs_pkg::PDATA_W'(hbs_pkg::WREG_W'(wm1) + hbs_pkg::WREG_W'(1));
      hbs_pkg::REG_IMAGE_ROWS:
        prdata = hbs_pkg::PDATA_W'(hbs_pkg::RREG_W'(rm1) + hbs_pkg::RREG_W'(1));
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= CW'(hbs_pkg::MAX_WIDTH - 1);
      rm1 <= RW'(1024 - 1);
    end else if (cfg_wr) begin
      case (cfg_sel)
        hbs_pkg::REG_IMAGE_WIDTH: wm1 <= hbs_pkg::width_last(pwdata[hbs_pkg::WREG_W-1:0]);
        hbs_pkg::REG_IMAGE_ROWS:  rm1 <= hbs_pkg::rows_last(pwdata[hbs_pkg::RREG_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- raster counters ----------------
  assign accept = samples.valid && s1_free;
  assign samples.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_cnt == wm1) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == rm1) ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // ---------------- line buffers ----------------
  // Read at acceptance, write back when the item leaves the RMW stage
  always_ff @(posedge clk) begin
    if (accept) begin
      older_q <= older_mem[col_cnt];
    end
    if (s1_done) begin
      older_mem[s1_c] <= newer_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newer_q <= newer_mem[col_cnt];
    end
    if (s1_done) begin
      newer_mem[s1_c] <= s1_sample;
    end
  end

  // Same column read while it is written: take the written values
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (accept) begin
      fwd <= s1_done && (col_cnt == s1_c);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      wr_older <= newer_eff;
      wr_newer <= s1_sample;
    end
  end

  assign older_eff = fwd ? wr_older : older_q;
  assign newer_eff = fwd ? wr_newer : newer_q;

  // ---------------- RMW stage ----------------
  // Positions completed by this sample: up-left, up, left, self
  always_comb begin
    s1_mask[0] = (s1_r != '0) && (s1_c != '0);
    s1_mask[1] = (s1_r != '0) && (s1_c == wm1);
    s1_mask[2] = (s1_r == rm1) && (s1_c != '0);
    s1_mask[3] = (s1_r == rm1) && (s1_c == wm1);
  end

  assign s1_done = s1_valid && ((s1_mask == '0) || job_free);
  assign s1_free = !s1_valid || s1_done;
  assign s1_load = s1_done && (s1_mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= row_cnt;
      s1_c      <= col_cnt;
      s1_sample <= samples.height_sample;
    end
  end

  // Window shift: rows are older line, newer line, current sample
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3]   = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = older_eff;
    win_next[5] = newer_eff;
    win_next[8] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hbs_pkg::WIN_N; i++) begin
        win[i] <= '0;
      end
    end else if (s1_done) begin
      win <= win_next;
    end
  end

  // ---------------- result job ----------------
  always_comb begin
    idx = '0;
    for (int i = 3; i >= 0; i--) begin
      if (job_mask[i]) begin
        idx = 2'(i);
      end
    end
    job_rest = job_mask & ~(4'b0001 << idx);
    job_last = (job_rest == '0);

    // Window rows / columns that hold in-bounds neighbours
    rmask = {1'b1, job_rge1, !idx[1] && job_rge2};
    cmask = {1'b1, job_cge1, !idx[0] && job_cge2};
    nrows = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
    ncols = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);

    req.sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (rmask[k] && cmask[j]) begin
          req.sum = req.sum + hbs_pkg::SUM_W'(job_win[k*3+j]);
        end
      end
    end
    req.cnt        = hbs_pkg::CNT_W'(nrows) * hbs_pkg::CNT_W'(ncols);
    req.row        = idx[1] ? job_r : job_r - RW'(1);
    req.col        = idx[0] ? job_c : job_c - CW'(1);
    req.last       = job_last;
    req.frame_done = idx[1] && idx[0];
  end

  assign job_emit = job_valid && req_ready;
  assign job_free = !job_valid || (job_emit && job_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_mask  <= '0;
    end else if (s1_load) begin
      job_valid <= 1'b1;
      job_mask  <= s1_mask;
    end else if (job_emit) begin
      job_mask <= job_rest;
      if (job_last) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      job_win  <= win_next;
      job_r    <= s1_r;
      job_c    <= s1_c;
      job_rge1 <= (s1_r != '0);
      job_rge2 <= (s1_r > RW'(1));
      job_cge1 <= (s1_c != '0);
      job_cge2 <= (s1_c > CW'(1));
    end
  end

  // ---------------- divide and output ----------------
  hbs_mean_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (job_valid),
    .req_ready (req_ready),
    .req       (req),
    .results   (results)
  );

`ifndef SYNTH
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_mask != '0))
    else $error("result job live with no positions left");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (col_cnt <= wm1) && (row_cnt <= rm1))
    else $error("raster counter beyond map size");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.frame_done) |-> results.last_of_run)
    else $error("frame end not flagged as last of run");
`endif

endmodule

`default_nettype wire

>>> dv/tb_heightmap_box_smoother_top.sv
// ----------------------------------------------------------------------------
// tb_heightmap_box_smoother_top - self-checking bench for the box smoother
// Streams heightmap frames of many sizes through the block under random and
// long stalls. A bit-true model of the 3x3 edge-normalised mean predicts
// every smoothed position, and each result item is checked field by field in
// arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_heightmap_box_smoother_top;
  import hbs_pkg::*;

  localparam int SETTLE_CYCLES = 12;   // block latency plus margin
  localparam int RESET_CYCLES  = 6;

  // One expected smoothed position
  typedef struct packed {
    logic [RES_W-1:0] height;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } smoothed_t;

  logic clk = 1'b0;
  logic rst;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  wire  [PDATA_W-1:0]  prdata;
  wire                 pready;

  hbs_sample_if smp ();
  hbs_result_if res ();

  heightmap_box_smoother_top uut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Predictor state: geometry, raster position, line stores, window
  int unsigned     geom_width, geom_rows;
  int unsigned     raster_row, raster_col;
  logic [SAMPLE_W-1:0] line_older [MAX_WIDTH];
  logic [SAMPLE_W-1:0] line_newer [MAX_WIDTH];
  logic [SAMPLE_W-1:0] box [WIN_N];

  smoothed_t pending_smoothed [$];
  smoothed_t head_smoothed;

  int errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_req = 0;    // set by a test, taken over by the result process
  int hold_left = 0;

  function automatic int unsigned clamp_extent(input int unsigned v, input int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int lesser(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Floored 16.4 mean of the in-bounds neighbours of (pr,pc), newest sample at (r,c)
  function automatic logic [RES_W-1:0] box_mean(input int pr, input int pc,
                                                input int r, input int c);
    int unsigned sum, cnt;
    int nr, nc, wr, wc;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = pr + dr;
        nc = pc + dc;
        wr = nr - (r - 2);
        wc = nc - (c - 2);
        if (nr >= 0 && nc >= 0 && nr < int'(geom_rows) && nc < int'(geom_width) &&
            wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
          sum += box[wr*3 + wc];
          cnt++;
        end
      end
    end
    if (cnt == 0) return '0;
    return RES_W'((sum * 16) / cnt);
  endfunction

  // Take one sample into the predictor and queue the positions it completes
  function automatic void smooth_window_step(input logic [SAMPLE_W-1:0] value);
    smoothed_t batch [4];
    int n, r, c, pr, pc, rr, ww;
    n = 0;
    if (raster_col >= geom_width) raster_col = 0;
    if (raster_row >= geom_rows) raster_row = 0;
    r  = int'(raster_row);
    c  = int'(raster_col);
    rr = int'(geom_rows);
    ww = int'(geom_width);
    for (int k = 0; k < 3; k++) begin
      box[k*3 + 0] = box[k*3 + 1];
      box[k*3 + 1] = box[k*3 + 2];
    end
    box[2] = line_older[c];
    box[5] = line_newer[c];
    box[8] = value;
    line_older[c] = line_newer[c];
    line_newer[c] = value;
    for (int a = -1; a <= 0; a++) begin
      for (int b = -1; b <= 0; b++) begin
        pr = r + a;
        pc = c + b;
        if (pr >= 0 && pc >= 0 && lesser(pr + 1, rr - 1) == r &&
            lesser(pc + 1, ww - 1) == c) begin
          batch[n].height = box_mean(pr, pc, r, c);
          batch[n].row    = ROW_W'(pr);
          batch[n].col    = COL_W'(pc);
          batch[n].last   = 1'b0;
          batch[n].done   = (pr == rr - 1 && pc == ww - 1);
          n++;
        end
      end
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_smoothed.push_back(batch[i]);
    raster_col++;
    if (raster_col >= geom_width) begin
      raster_col = 0;
      raster_row++;
      if (raster_row >= geom_rows) raster_row = 0;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: check each accepted item, then choose ready for the next cycle
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (pending_smoothed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                 $time, res.out_row, res.out_col, res.smoothed_height);
        errors++;
      end else begin
        head_smoothed = pending_smoothed.pop_front();
        compare_field("smoothed_height", 32'(head_smoothed.height), 32'(res.smoothed_height));
        compare_field("out_row", 32'(head_smoothed.row), 32'(res.out_row));
        compare_field("out_col", 32'(head_smoothed.col), 32'(res.out_col));
        compare_field("last_of_run", 32'(head_smoothed.last), 32'(res.last_of_run));
        compare_field("frame_done", 32'(head_smoothed.done), 32'(res.frame_done));
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else begin
      res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offer one sample, with a random gap first, and wait for it to be taken
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid         <= 1'b1;
    smp.height_sample <= value;
    do @(posedge clk); while (smp.ready !== 1'b1);
    smooth_window_step(value);
  endtask

  // Stop offering, let every expected result arrive, then let the pipe empty
  task automatic wait_drain();
    smp.valid <= 1'b0;
    while (pending_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase, then back to idle
  task automatic program_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) geom_width = clamp_extent(value & 32'h7FF, MAX_WIDTH);
    else                        geom_rows  = clamp_extent(value & 32'h1FFF, MAX_ROWS);
    raster_row = 0;
    raster_col = 0;
  endtask

  task automatic set_geometry(input int unsigned width_raw, input int unsigned rows_raw);
    wait_drain();
    program_reg(REG_IMAGE_WIDTH, PDATA_W'(width_raw));
    program_reg(REG_IMAGE_ROWS, PDATA_W'(rows_raw));
  endtask

  // Mostly random heights, with the extremes often enough to matter
  function automatic logic [SAMPLE_W-1:0] rand_height();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // ---- directed ----------------------------------------------------------

  // Zero sizes act as one: every sample is a whole map of its own
  task automatic test_single_position();
    set_geometry(0, 0);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    push_sample(16'h8000);
  endtask

  // One column, then the frame wraps and a second one starts
  task automatic test_single_column();
    set_geometry(1, 3);
    repeat (3) push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h5555);
  endtask

  task automatic test_single_row();
    set_geometry(3, 1);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'hAAAA);
  endtask

  // 2x2: last sample completes four corners; 3x3 of maximum: full window
  task automatic test_full_neighbourhood();
    set_geometry(2, 2);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'hFFFE);
    set_geometry(3, 3);
    repeat (9) push_sample(16'hFFFF);
  endtask

  // ---- stalls ------------------------------------------------------------

  // Long receiver hold-off fills the block; then a pause until all is out
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_geometry(6, 8);
    hold_req = 300;
    repeat (24) push_sample(rand_height());
    wait_drain();
    repeat (24) push_sample(rand_height());
  endtask

  // ---- random frames -----------------------------------------------------

  task automatic test_random_frames(input int budget, input int src_pct, input int snk_pct);
    int sent, n, frames, sel;
    int unsigned w_raw, r_raw;
    sent = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < budget) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        w_raw = $urandom_range(1, 4);
        r_raw = $urandom_range(4097, 8191);
      end else if (sel == 1) begin
        w_raw = 0;
        r_raw = $urandom_range(0, 5);
      end else begin
        w_raw = $urandom_range(1, 9);
        r_raw = $urandom_range(1, 7);
      end
      set_geometry(w_raw, r_raw);
      if (geom_width * geom_rows <= 64) begin
        frames = $urandom_range(1, 3);
        n = frames * int'(geom_width * geom_rows);
        // now and then cut the stream short in mid frame
        if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      end else begin
        n = $urandom_range(8, 40);
      end
      if (n > budget - sent) n = budget - sent;
      repeat (n) push_sample(rand_height());
      sent += n;
    end
  endtask

  // ---- largest sizes -----------------------------------------------------

  // Width clamped to the maximum on a one-row map: the start of the row
  task automatic test_max_width();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_geometry(2047, 1);
    repeat (20) push_sample(rand_height());
  endtask

  // Rows clamped to the maximum on a one-column map: the first rows
  task automatic test_max_rows();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_geometry(1, 8191);
    repeat (20) push_sample(rand_height());
  endtask

  // Sequencer
  initial begin
    rst               = 1'b1;
    smp.valid         = 1'b0;
    smp.height_sample = '0;
    res.ready         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    geom_width        = 1024;
    geom_rows         = 1024;
    raster_row        = 0;
    raster_col        = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    for (int i = 0; i < WIN_N; i++) box[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 9;
    snk_idle_pct = 66;
    test_single_position();
    test_single_column();
    test_single_row();
    test_full_neighbourhood();
    test_random_frames(55, 9, 66);
    test_random_frames(55, 66, 9);
    test_random_frames(55, 0, 0);
    test_backpressure();
    test_max_width();
    test_max_rows();

    wait_drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/hbs_pkg.sv
design/hbs_sample_if.sv
design/hbs_result_if.sv
design/hbs_mean_div.sv
design/heightmap_box_smoother_top.sv
dv/tb_heightmap_box_smoother_top.sv
